/* design/rrca_pkg.sv */
// ----------------------------------------------------------------------------
// rrca_pkg
// Types and constants shared by the channel averager and its divider.
// ----------------------------------------------------------------------------
package rrca_pkg;

    localparam int MOTOR_COUNT_DEF = 2;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int CHAN_N          = 6;
    localparam int SUM_W           = 50;

    typedef struct packed {
        logic               op;
        logic               motor_index;
        logic [5:0]         read_select;
        logic signed [15:0] id_value;
        logic signed [15:0] iq_value;
        logic signed [15:0] dc_value;
        logic signed [15:0] vd_value;
        logic signed [15:0] vq_value;
    } t_in_item;

    typedef struct packed {
        logic signed [16:0] avg_motor_current;
        logic signed [15:0] avg_input_current;
        logic signed [15:0] avg_d_current;
        logic signed [15:0] avg_q_current;
        logic signed [15:0] avg_d_voltage;
        logic signed [15:0] avg_q_voltage;
        logic [5:0]         from_accumulator;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CHAN,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

/* design/read_reset_channel_averager.sv */
// ----------------------------------------------------------------------------
// read_reset_channel_averager
// Per-motor accumulate-and-dump averager over six current and voltage channels.
// ----------------------------------------------------------------------------
// Input transactions carry an op bit: a sample adds six live values (the signed
// current magnitude is a floor square root of Id^2 + Iq^2) to the chosen
// motor's saturating sums and counts; a read returns one output transaction
// with sum/count for each selected channel and clears those channels.
// Channels not selected, or with a zero count, return the live value.
// After acceptance a transaction passes through the square root (one result
// bit per cycle), then steps through the channels in turn. A read also runs
// each selected channel with a nonzero count through the shared restoring
// divider and then loads the output register. The input is stalled for the
// whole time.
// The result sits in an output register; while the receiver stalls, the block
// holds it and takes no new input transaction until it is taken.
// Reset clears all sums, counts and control state together, since the
// accumulators are only MOTOR_COUNT x 6 registers.
// ----------------------------------------------------------------------------
module read_reset_channel_averager #(
    parameter int MOTOR_COUNT = rrca_pkg::MOTOR_COUNT_DEF,
    parameter int COUNT_BITS  = rrca_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rrca_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output rrca_pkg::t_out_item o_data
);
    import rrca_pkg::*;

    localparam int NACC = MOTOR_COUNT * CHAN_N;
    localparam int AW   = (NACC > 1) ? $clog2(NACC) : 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Accumulator registers, each row read through the channel index.
    logic signed [SUM_W-1:0] r_sum [NACC];
    logic [COUNT_BITS-1:0]   r_cnt [NACC];

    t_state r_state, n_state;
    t_in_item r_in;
    logic [31:0] r_rad;
    logic [16:0] r_root;
    logic [17:0] r_rem;
    logic [4:0]  r_step;
    logic [2:0]  r_ch;
    logic signed [16:0] r_live [1:CHAN_N-1];
    logic signed [16:0] r_res  [CHAN_N];
    logic [5:0]  r_flags;
    logic        r_neg;
    logic        r_qneg;
    logic        r_valid;

    logic        w_motor_ok;
    logic [AW-1:0] w_idx;
    logic signed [SUM_W-1:0] w_sum;
    logic [COUNT_BITS-1:0]   w_cnt;
    logic signed [SUM_W:0]   w_add;
    logic        w_sel;
    logic        w_div_start;
    logic        w_div_done;
    logic [SUM_W-1:0] w_quot;
    logic [SUM_W-1:0] w_mag;
    logic signed [SUM_W:0] w_q;
    logic signed [16:0] w_hi, w_lo;
    logic signed [16:0] w_sat;
    logic signed [31:0] w_id32, w_iq32;
    logic [31:0]      w_sq;
    logic [19:0]      w_rem_t;
    logic [19:0]      w_cmp;
    logic signed [16:0] w_live0;
    logic signed [16:0] w_live;

    // Signed current magnitude, valid once the root is complete.
    assign w_live0 = r_neg ? -$signed({1'b0, r_root[15:0]}) : $signed({1'b0, r_root[15:0]});

    always_comb begin
        case (r_ch)
            3'd0:    w_live = w_live0;
            3'd1:    w_live = r_live[1];
            3'd2:    w_live = r_live[2];
            3'd3:    w_live = r_live[3];
            3'd4:    w_live = r_live[4];
            3'd5:    w_live = r_live[5];
            default: w_live = '0;
        endcase
    end

    assign w_motor_ok = (32'(r_in.motor_index) < 32'(MOTOR_COUNT));
    assign w_idx = AW'(32'(r_in.motor_index) * CHAN_N + 32'(r_ch));
    assign w_sum = w_motor_ok ? r_sum[w_idx] : '0;
    assign w_cnt = w_motor_ok ? r_cnt[w_idx] : '0;
    assign w_add = (SUM_W+1)'(w_sum) + (SUM_W+1)'(w_live);
    assign w_sel = w_motor_ok && r_in.read_select[r_ch];
    assign w_mag = w_sum[SUM_W-1] ? SUM_W'(-w_sum) : w_sum;

    // Radicand for the square root; the sum of two squares fits 32 bits.
    assign w_id32 = 32'(i_data.id_value);
    assign w_iq32 = 32'(i_data.iq_value);
    assign w_sq   = w_id32 * w_id32 + w_iq32 * w_iq32;

    // One bit of the square root per cycle, two radicand bits at a time.
    assign w_rem_t = {r_rem, r_rad[31:30]};
    assign w_cmp   = {1'b0, r_root, 2'b01};

    assign w_div_start = (r_state == ST_CHAN) && r_in.op && w_sel && (w_cnt != '0);

    rrca_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (w_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_q  = r_qneg ? -(SUM_W+1)'(signed'({1'b0, w_quot}))
                         : (SUM_W+1)'(signed'({1'b0, w_quot}));
    assign w_hi = (r_ch == 3'd0) ? 17'sd46341 : 17'sd32767;
    assign w_lo = (r_ch == 3'd0) ? -17'sd46341 : -17'sd32768;
    always_comb begin
        if (w_q > (SUM_W+1)'(w_hi))      w_sat = w_hi;
        else if (w_q < (SUM_W+1)'(w_lo)) w_sat = w_lo;
        else                             w_sat = w_q[16:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid && !o_stall) n_state = ST_SQRT;
            ST_SQRT: if (r_step == 5'd15) n_state = ST_CHAN;
            ST_CHAN: begin
                if (w_div_start) n_state = ST_DIV;
                else if (r_ch == 3'(CHAN_N - 1)) n_state = r_in.op ? ST_OUT : ST_IDLE;
            end
            ST_DIV: begin
                if (w_div_done) n_state = (r_ch == 3'(CHAN_N - 1)) ? ST_OUT : ST_CHAN;
            end
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != ST_IDLE) || r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            for (int k = 0; k < NACC; k++) begin
                r_sum[k] <= '0;
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_in    <= i_data;
                        r_rad   <= w_sq;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_step  <= '0;
                        r_ch    <= '0;
                        r_flags <= '0;
                        r_neg   <= i_data.vq_value[15] != i_data.iq_value[15];
                    end
                end
                ST_SQRT: begin
                    r_rad  <= {r_rad[29:0], 2'b00};
                    r_step <= r_step + 1'b1;
                    if (w_rem_t >= w_cmp) begin
                        r_rem  <= 18'(w_rem_t - w_cmp);
                        r_root <= {r_root[15:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_t[17:0];
                        r_root <= {r_root[15:0], 1'b0};
                    end
                    if (r_step == 5'd15) begin
                        r_live[1] <= 17'(r_in.dc_value);
                        r_live[2] <= 17'(r_in.id_value);
                        r_live[3] <= 17'(r_in.iq_value);
                        r_live[4] <= 17'(r_in.vd_value);
                        r_live[5] <= 17'(r_in.vq_value);
                    end
                end
                ST_CHAN: begin
                    if (!r_in.op) begin
                        if (w_motor_ok) begin
                            if (w_add > (SUM_W+1)'(SMAX))      r_sum[w_idx] <= SMAX;
                            else if (w_add < (SUM_W+1)'(SMIN)) r_sum[w_idx] <= SMIN;
                            else r_sum[w_idx] <= w_add[SUM_W-1:0];
                            if (w_cnt != CMAX) r_cnt[w_idx] <= w_cnt + 1'b1;
                        end
                    end else begin
                        r_res[r_ch] <= w_live;
                        if (w_sel) begin
                            r_sum[w_idx] <= '0;
                            r_cnt[w_idx] <= '0;
                        end
                    end
                    if (w_div_start) r_qneg <= w_sum[SUM_W-1];
                    if (!w_div_start) r_ch <= r_ch + 1'b1;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_res[r_ch]   <= w_sat;
                        r_flags[r_ch] <= 1'b1;
                        r_ch          <= r_ch + 1'b1;
                    end
                end
                ST_OUT: begin
                    r_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // The divider latches its operands at start and the sign of the sum is kept
    // in r_qneg, so clearing the channel in the same cycle is safe.

    assign o_valid = r_valid;
    always_comb begin
        o_data.avg_motor_current = (r_flags[0]) ? r_res[0] : w_live0;
        o_data.avg_input_current = r_res[1][15:0];
        o_data.avg_d_current     = r_res[2][15:0];
        o_data.avg_q_current     = r_res[3][15:0];
        o_data.avg_d_voltage     = r_res[4][15:0];
        o_data.avg_q_voltage     = r_res[5][15:0];
        o_data.from_accumulator  = r_flags;
    end
endmodule

/* design/rrca_divider.sv */
// ----------------------------------------------------------------------------
// rrca_divider
// Restoring divider, one quotient bit per cycle, magnitude 50 by COUNT_BITS.
// ----------------------------------------------------------------------------
module rrca_divider #(
    parameter int COUNT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rrca_pkg::SUM_W-1:0]    i_dividend,
    input  logic [COUNT_BITS-1:0]         i_divisor,
    output logic                          o_done,
    output logic [rrca_pkg::SUM_W-1:0]    o_quotient
);
    import rrca_pkg::*;

    localparam int CW = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]      r_q;
    logic [COUNT_BITS:0]   r_rem;
    logic [COUNT_BITS-1:0] r_div;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic [COUNT_BITS:0]   w_trial;
    logic [COUNT_BITS:0]   w_diff;

    assign w_trial = {r_rem[COUNT_BITS-1:0], r_q[SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SUM_W);
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (w_trial >= {1'b0, r_div}) begin
                    r_rem <= w_diff;
                    r_q   <= {r_q[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[SUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_q;
endmodule
